### design/mh64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_pkg
// shared types, constants and command codes of the 64-bit murmur hash block
// ----------------------------------------------------------------------------
package mh64_pkg;

    localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
    localparam int          MIX_SHIFT = 47;

    typedef struct packed {
        logic [30:0] key_length;
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        first_word;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        bad_framing;
    } out_item_t;

    // multiplier operand select
    localparam logic [1:0] OP_LEN = 2'd0;
    localparam logic [1:0] OP_K   = 2'd1;
    localparam logic [1:0] OP_HK  = 2'd2;
    localparam logic [1:0] OP_FIN = 2'd3;

    // product write-back select
    localparam logic [2:0] WR_NONE   = 3'd0;
    localparam logic [2:0] WR_H_SEED = 3'd1;
    localparam logic [2:0] WR_K_MIX  = 3'd2;
    localparam logic [2:0] WR_K      = 3'd3;
    localparam logic [2:0] WR_H      = 3'd4;
    localparam logic [2:0] WR_OUT    = 3'd5;

    typedef struct packed {
        logic       capture;
        logic       mul_load;
        logic [1:0] mul_sel;
        logic [2:0] wr_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic new_first;
        logic new_last;
        logic new_full;
        logic new_part;
        logic cur_last;
        logic cur_full;
        logic cur_part;
        logic out_free;
    } dp_status_t;

endpackage

### design/murmur_hash_64a.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur_hash_64a
// streaming 64-bit murmur hash (64a variant) over little-endian key words
// ----------------------------------------------------------------------------
// timing: an item is captured while the sequencer is idle, then its multiply
//   passes run in turn on the single shared registered multiplier: seed start for
//   a first word, two key mixes and a hash update for a full word, one hash update
//   for a partial word, finalisation for a last word, which also waits while an
//   earlier hash sits stalled in the result register
// a new item is taken only once the previous one has finished all its passes
// the result register frees the input side while a hash waits to be taken
// reset (rst_n low, asynchronous): seed, running hash and framing flag clear,
//   sequencer to idle, no result pending
module murmur_hash_64a (
    input  logic                clk,
    input  logic                rst_n,
    // input items
    input  logic                in_valid,
    output logic                in_stall,
    input  mh64_pkg::in_item_t  in_data,
    // result items
    output logic                out_valid,
    input  logic                out_stall,
    output mh64_pkg::out_item_t out_data,
    // seed register write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);
    import mh64_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // seed is taken whenever offered
    assign cfg_ready = 1'b1;

    // sequencer: decides which multiply pass runs next from the item flags
    mh64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: hash state, mix temp, shared multiplier and result register
    mh64_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### design/mh64_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_mult
// registered multiply by the mix constant modulo 2^64, from 32x32 partial products
// ----------------------------------------------------------------------------
module mh64_mult (
    input  logic        clk,
    input  logic        load,
    input  logic [63:0] operand,
    output logic [63:0] product
);
    import mh64_pkg::*;

    localparam logic [31:0] MULT_LO = MIX_MULT[31:0];
    localparam logic [31:0] MULT_HI = MIX_MULT[63:32];

    logic [63:0] p_ll_reg;
    logic [31:0] p_hl_reg;
    logic [31:0] p_lh_reg;
    logic [63:0] p_ll_next;
    logic [63:0] p_hl_full;
    logic [63:0] p_lh_full;
    logic [31:0] cross_sum;

    always_comb
    begin
        p_ll_next = operand[31:0] * MULT_LO;
        p_hl_full = operand[63:32] * MULT_LO;
        p_lh_full = operand[31:0] * MULT_HI;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_ll_reg <= p_ll_next;
            p_hl_reg <= p_hl_full[31:0];
            p_lh_reg <= p_lh_full[31:0];
        end
    end

    assign cross_sum = p_hl_reg + p_lh_reg;
    assign product   = p_ll_reg + {cross_sum, 32'd0};

endmodule

### design/mh64_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_datapath
// item capture, hash and mix registers, shared multiplier and result register
// ----------------------------------------------------------------------------
module mh64_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mh64_pkg::in_item_t  in_data,
    input  logic                cfg_valid,
    input  logic [31:0]         cfg_data,
    input  mh64_pkg::dp_cmd_t   cmd,
    output mh64_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_stall,
    output mh64_pkg::out_item_t out_data
);
    import mh64_pkg::*;

    logic [31:0] seed_reg;
    logic [63:0] h_reg, h_next;
    logic [63:0] k_reg, k_next;
    logic        err_reg, err_next;
    logic [30:0] len_reg;
    logic        last_reg, full_reg, part_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg;

    logic        new_full, new_part;
    logic [63:0] byte_mask;
    logic [63:0] mul_operand;
    logic [63:0] product;
    logic [63:0] product_mix;
    logic [63:0] h_fold;

    assign new_full = in_data.byte_count[3];
    assign new_part = !in_data.byte_count[3] && (in_data.byte_count != 4'd0);

    // keep byte i when i is below the byte count
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_mask[i*8 +: 8] = (new_full || (4'(i) < in_data.byte_count)) ? 8'hff : 8'h00;
        end
    end

    assign h_fold = h_reg ^ (h_reg >> MIX_SHIFT);

    always_comb
    begin
        case (cmd.mul_sel)
            OP_LEN:  mul_operand = {33'd0, len_reg};
            OP_K:    mul_operand = k_reg;
            OP_HK:   mul_operand = h_reg ^ k_reg;
            OP_FIN:  mul_operand = h_fold;
            default: mul_operand = k_reg;
        endcase
    end

    mh64_mult u_mult (
        .clk     (clk),
        .load    (cmd.mul_load),
        .operand (mul_operand),
        .product (product)
    );

    assign product_mix = product ^ (product >> MIX_SHIFT);

    always_comb
    begin
        h_next   = h_reg;
        k_next   = k_reg;
        err_next = err_reg;
        if (cmd.capture)
        begin
            k_next   = in_data.data_word & byte_mask;
            err_next = (in_data.first_word ? 1'b0 : err_reg)
                     | (!new_full && !in_data.last_word);
        end
        case (cmd.wr_sel)
            WR_H_SEED: h_next = {32'd0, seed_reg} ^ product;
            WR_K_MIX:  k_next = product_mix;
            WR_K:      k_next = product;
            WR_H:      h_next = product;
            default:   ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.wr_sel == WR_OUT)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            h_reg         <= 64'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= cfg_data;
            end
            h_reg         <= h_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.capture)
        begin
            len_reg   <= in_data.key_length;
            last_reg  <= in_data.last_word;
            full_reg  <= new_full;
            part_reg  <= new_part;
        end
        if (cmd.wr_sel == WR_OUT)
        begin
            out_reg.hash_value  <= product_mix;
            out_reg.bad_framing <= err_reg;
        end
    end

    always_comb
    begin
        status.new_first = in_data.first_word;
        status.new_last  = in_data.last_word;
        status.new_full  = new_full;
        status.new_part  = new_part;
        status.cur_last  = last_reg;
        status.cur_full  = full_reg;
        status.cur_part  = part_reg;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### design/mh64_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_ctrl
// sequencer that steps one item through the shared multiplier
// ----------------------------------------------------------------------------
module mh64_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mh64_pkg::dp_status_t status,
    output mh64_pkg::dp_cmd_t    cmd
);
    import mh64_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LEN_P = 4'd1;
    localparam logic [3:0] S_LEN_S = 4'd2;
    localparam logic [3:0] S_K1_P  = 4'd3;
    localparam logic [3:0] S_K1_S  = 4'd4;
    localparam logic [3:0] S_K2_P  = 4'd5;
    localparam logic [3:0] S_K2_S  = 4'd6;
    localparam logic [3:0] S_H_P   = 4'd7;
    localparam logic [3:0] S_H_S   = 4'd8;
    localparam logic [3:0] S_F_P   = 4'd9;
    localparam logic [3:0] S_F_S   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [3:0] after_h_cur, after_len_cur;
    logic [3:0] after_h_new, after_len_new, after_cap;

    assign after_h_cur   = status.cur_last ? S_F_P : S_IDLE;
    assign after_len_cur = status.cur_full ? S_K1_P : (status.cur_part ? S_H_P : after_h_cur);
    assign after_h_new   = status.new_last ? S_F_P : S_IDLE;
    assign after_len_new = status.new_full ? S_K1_P : (status.new_part ? S_H_P : after_h_new);
    assign after_cap     = status.new_first ? S_LEN_P : after_len_new;

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.mul_load = 1'b0;
        cmd.mul_sel  = OP_K;
        cmd.wr_sel   = WR_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = after_cap;
                end
            end
            S_LEN_P:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = OP_LEN;
                state_next   = S_LEN_S;
            end
            S_LEN_S:
            begin
                cmd.wr_sel = WR_H_SEED;
                state_next = after_len_cur;
            end
            S_K1_P:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = OP_K;
                state_next   = S_K1_S;
            end
            S_K1_S:
            begin
                cmd.wr_sel = WR_K_MIX;
                state_next = S_K2_P;
            end
            S_K2_P:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = OP_K;
                state_next   = S_K2_S;
            end
            S_K2_S:
            begin
                cmd.wr_sel = WR_K;
                state_next = S_H_P;
            end
            S_H_P:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = OP_HK;
                state_next   = S_H_S;
            end
            S_H_S:
            begin
                cmd.wr_sel = WR_H;
                state_next = after_h_cur;
            end
            S_F_P:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = OP_FIN;
                state_next   = S_F_S;
            end
            S_F_S:
            begin
                if (status.out_free)
                begin
                    cmd.wr_sel = WR_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### design/mh64_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_checker
// port-level checks of the murmur hash block, bound to the top level
// ----------------------------------------------------------------------------
module mh64_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input mh64_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input mh64_pkg::out_item_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a first word always needs the multiplier, so the block goes busy
    a_first_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.first_word |=> in_stall)
        else $error("first word did not occupy the block");

    // an empty continuation word finishes at once
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !in_data.first_word && !in_data.last_word
        && (in_data.byte_count == 4'd0) |=> !in_stall)
        else $error("empty word kept the block busy");

    // a new result only appears after the block was busy with an item
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work in progress");

endmodule

bind murmur_hash_64a mh64_checker u_chk (.*);

### tb/tb_murmur_hash_64a.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur_hash_64a
// self-checking bench for the streaming 64-bit murmur hash block: keys are
// streamed as word items under random sender bursts and receiver stalls, a
// local hash model predicts every result and a checker compares each one
// ----------------------------------------------------------------------------
module tb_murmur_hash_64a;

    import mh64_pkg::*;

    // run limits
    localparam int ITEM_TARGET  = 1120;
    localparam int DRAIN_CYCLES = 16;       // comfortably above the worst case for one item
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SEED_PERIOD  = 200;      // items between seed changes in the random part

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_PERIOD = 3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [31:0] cfg_data = '0;

    // hash model state
    logic [63:0] seed_model    = '0;
    logic [63:0] hash_acc      = '0;
    logic        framing_model = 1'b0;
    out_item_t   expected_hashes[$];

    int cycle_count    = 0;
    int items_sent     = 0;
    int hashes_checked = 0;
    int framing_seen   = 0;
    int seed_writes    = 0;
    int errors         = 0;
    int burst_left     = 0;
    int stall_mode     = STALL_NONE;
    int stall_left     = 0;

    murmur_hash_64a i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // hash model
    // ------------------------------------------------------------------------

    function automatic logic [63:0] mix_key(logic [63:0] k);
        k = k * MIX_MULT;
        k = k ^ (k >> MIX_SHIFT);
        k = k * MIX_MULT;
        return k;
    endfunction

    function automatic logic [63:0] finalise_hash(logic [63:0] h);
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_MULT;
        h = h ^ (h >> MIX_SHIFT);
        return h;
    endfunction

    // folds one accepted word into the model and queues the hash on a last word
    task automatic predict_hash(input in_item_t it);
        int          nbytes;
        logic [63:0] mask;
        out_item_t   res;
        nbytes = (it.byte_count > 4'd8) ? 8 : int'(it.byte_count);
        if (it.first_word)
        begin
            hash_acc      = seed_model ^ (64'(it.key_length) * MIX_MULT);
            framing_model = 1'b0;
        end
        if (nbytes == 8)
        begin
            hash_acc = (hash_acc ^ mix_key(it.data_word)) * MIX_MULT;
        end
        else if (nbytes > 0)
        begin
            mask     = (64'h1 << (8 * nbytes)) - 64'h1;
            hash_acc = (hash_acc ^ (it.data_word & mask)) * MIX_MULT;
        end
        // a short word anywhere but at the end spoils the framing
        if (nbytes < 8 && !it.last_word)
            framing_model = 1'b1;
        if (it.last_word)
        begin
            res.hash_value  = finalise_hash(hash_acc);
            res.bad_framing = framing_model;
            expected_hashes.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver side: stall pattern and result checker
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_PERIOD);
            stall_left <= $urandom_range(100, 400);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
            default:      out_stall <= ((cycle_count % 32) < 20);
        endcase
    end

    always @(posedge clk)
    begin : hash_checker
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hashes.size() == 0)
            begin
                $display("%0t: unexpected result, hash %h bad_framing %b", $time,
                         out_data.hash_value, out_data.bad_framing);
                errors++;
            end
            else
            begin
                want = expected_hashes.pop_front();
                if (out_data.hash_value !== want.hash_value)
                begin
                    $display("%0t: hash_value mismatch, expected %h actual %h", $time,
                             want.hash_value, out_data.hash_value);
                    errors++;
                end
                if (out_data.bad_framing !== want.bad_framing)
                begin
                    $display("%0t: bad_framing mismatch, expected %b actual %b", $time,
                             want.bad_framing, out_data.bad_framing);
                    errors++;
                end
                if (want.bad_framing)
                    framing_seen++;
                hashes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic in_item_t make_item(logic [30:0] len, logic [63:0] word,
                                           logic [3:0] cnt, logic first, logic last);
        in_item_t it;
        it.key_length = len;
        it.data_word  = word;
        it.byte_count = cnt;
        it.first_word = first;
        it.last_word  = last;
        return it;
    endfunction

    // drives one item and holds it until taken; bursts are broken by random gaps
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
        predict_hash(it);
    endtask

    // stops sending and lets every pending hash and any tail of work clear out
    task automatic wait_hashes_drained();
        in_valid <= 1'b0;
        while (expected_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_hashes_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        seed_model = {32'h0, value};
        seed_writes++;
    endtask

    // mostly well-formed keys; some carry a short word mid-key, a wrong length
    // or an oversize byte count
    task automatic send_random_key();
        int          n_full;
        int          tail;
        int          bad_pos;
        logic [30:0] len;
        logic [3:0]  cnt;
        logic        started;
        n_full  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
        tail    = $urandom_range(0, 7);
        bad_pos = (n_full > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, n_full - 1)
                                                            : -1;
        len     = ($urandom_range(0, 7) == 0) ? 31'($urandom()) : 31'(n_full * 8 + tail);
        started = 1'b0;
        if (n_full == 0 && tail == 0)
        begin
            send_item(make_item(len, rand_word(), 4'd0, 1'b1, 1'b1));
        end
        else
        begin
            for (int i = 0; i < n_full; i++)
            begin
                if (i == bad_pos)
                begin
                    send_item(make_item(len, rand_word(), 4'($urandom_range(0, 7)),
                                        !started, 1'b0));
                    started = 1'b1;
                end
                cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
                send_item(make_item(len, rand_word(), cnt, !started,
                                    (i == n_full - 1) && (tail == 0)));
                started = 1'b1;
            end
            if (tail > 0)
                send_item(make_item(len, rand_word(), 4'(tail), !started, 1'b1));
        end
    endtask

    task automatic send_noise_item();
        send_item(make_item(31'($urandom()), rand_word(), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    endtask

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 3))
            0:       return 32'hffffffff;
            1:       return 32'h00000000;
            2:       return 32'h80000000;
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // first item after reset has no first_word: it runs on from the cleared hash
    task automatic test_reset_continuation();
        send_item(make_item(31'd0, rand_word(), 4'd8, 1'b0, 1'b1));
    endtask

    task automatic test_special_keys();
        // empty key: seed start and finalisation only
        send_item(make_item(31'd0, rand_word(), 4'd0, 1'b1, 1'b1));
        send_item(make_item(31'd8, 64'h0, 4'd8, 1'b1, 1'b1));
        send_item(make_item(31'h7fffffff, 64'hffffffffffffffff, 4'd8, 1'b1, 1'b1));
        // short tails with every upper byte set, so masking shows
        for (int n = 1; n < 8; n++)
            send_item(make_item(31'(n), 64'hffffffffffffffff, 4'(n), 1'b1, 1'b1));
        // oversize byte counts fold in as full words
        send_item(make_item(31'd8, rand_word(), 4'd9, 1'b1, 1'b1));
        send_item(make_item(31'd8, rand_word(), 4'd15, 1'b1, 1'b1));
    endtask

    task automatic test_framing();
        // short word mid-key
        send_item(make_item(31'd19, rand_word(), 4'd8, 1'b1, 1'b0));
        send_item(make_item(31'd19, rand_word(), 4'd3, 1'b0, 1'b0));
        send_item(make_item(31'd19, rand_word(), 4'd8, 1'b0, 1'b1));
        // zero-byte word that is not last
        send_item(make_item(31'd8, rand_word(), 4'd0, 1'b1, 1'b0));
        send_item(make_item(31'd8, rand_word(), 4'd8, 1'b0, 1'b1));
        // carries on after a result, framing flag still set
        send_item(make_item(31'd0, rand_word(), 4'd8, 1'b0, 1'b1));
        // length does not match the bytes delivered
        send_item(make_item(31'd3, rand_word(), 4'd8, 1'b1, 1'b0));
        send_item(make_item(31'd3, rand_word(), 4'd8, 1'b0, 1'b1));
    endtask

    task automatic test_seed_extremes();
        write_seed(32'hffffffff);
        repeat (6) send_random_key();
        write_seed(32'h00000000);
        repeat (6) send_random_key();
        write_seed(32'h00000001);
        repeat (4) send_random_key();
    endtask

    task automatic test_random_keys();
        int next_seed_at;
        bit paused;
        next_seed_at = items_sent + SEED_PERIOD;
        paused       = 1'b0;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_seed_at)
            begin
                write_seed(pick_seed());
                next_seed_at = items_sent + SEED_PERIOD;
            end
            else if (!paused && items_sent >= ITEM_TARGET / 2)
            begin
                // hold the sender until every hash is back
                wait_hashes_drained();
                paused = 1'b1;
            end
            else if ($urandom_range(0, 6) == 0)
            begin
                send_noise_item();
            end
            else
            begin
                send_random_key();
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_continuation();
        test_special_keys();
        test_framing();
        test_seed_extremes();
        test_random_keys();

        wait_hashes_drained();
        $display("%0d items sent under %0d seed settings, %0d hashes checked",
                 items_sent, seed_writes, hashes_checked);
        $display("%0d hashes carried the framing flag, %0d mismatches", framing_seen, errors);
        if (errors == 0)
            $display("tb_murmur_hash_64a passed");
        else
            $display("tb_murmur_hash_64a failed");
        $finish;
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d hashes outstanding", cycle_count,
                 expected_hashes.size());
        $display("tb_murmur_hash_64a failed");
        $finish;
    end

endmodule
